@@ sv/dpsm_pkg.sv @@
// Shared types and constants for the drive power state machine.
// No dependencies; the decoder, transition logic, core and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package dpsm_pkg;

  typedef enum logic [3:0] {
    ST_START       = 4'd0,
    ST_NOT_READY   = 4'd1,
    ST_SW_DISABLED = 4'd2,
    ST_READY       = 4'd3,
    ST_SWITCHED_ON = 4'd4,
    ST_OP_ENABLED  = 4'd5,
    ST_QUICK_STOP  = 4'd6,
    ST_FAULT_REACT = 4'd7,
    ST_FAULT       = 4'd8
  } drive_state_t;

  localparam logic [1:0] MODE_CONTROL_WORD = 2'd0;
  localparam logic [1:0] MODE_FAULT        = 2'd1;
  localparam logic [1:0] MODE_STARTUP      = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SHUTDOWN,
    CMD_SWITCH_ON,
    CMD_DISABLE_VOLTAGE,
    CMD_QUICK_STOP,
    CMD_ENABLE_OP,
    CMD_FAULT_RESET
  } command_t;

  // Control word masks and match values.
  localparam logic [15:0] CW_SHUTDOWN_MASK   = 16'h0087;
  localparam logic [15:0] CW_SHUTDOWN_VAL    = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON_MASK  = 16'h008F;
  localparam logic [15:0] CW_SWITCH_ON_VAL   = 16'h0007;
  localparam logic [15:0] CW_DIS_VOLT_MASK   = 16'h0082;
  localparam logic [15:0] CW_DIS_VOLT_VAL    = 16'h0000;
  localparam logic [15:0] CW_QUICK_STOP_MASK = 16'h0086;
  localparam logic [15:0] CW_QUICK_STOP_VAL  = 16'h0002;
  localparam logic [15:0] CW_ENABLE_OP_MASK  = 16'h008F;
  localparam logic [15:0] CW_ENABLE_OP_VAL   = 16'h000F;
  localparam logic [15:0] CW_FAULT_RST_MASK  = 16'h0080;
  localparam logic [15:0] CW_FAULT_RST_VAL   = 16'h0080;

  typedef struct packed {
    logic drive_on;
    logic drive_off;
    logic power_cut;
    logic quick_stop;
    logic fault_react;
  } pulses_t;

  // Outcome of one transition step.
  typedef struct packed {
    drive_state_t next_state;
    logic         illegal;
    logic         set_online;
    pulses_t      pulses;
  } step_result_t;

endpackage

`default_nettype wire

@@ sv/dpsm_if.sv @@
// Handshake channel interfaces for the drive power state machine.
// Depends on nothing; payload widths follow the fixed field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpsm_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] control_word;
  modport source (output valid, mode, control_word, input ready);
  modport sink (input valid, mode, control_word, output ready);
endinterface

interface dpsm_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] drive_state;
  logic       status;
  logic       online;
  logic       drive_on_pulse;
  logic       drive_off_pulse;
  logic       power_cut_pulse;
  logic       quick_stop_pulse;
  logic       fault_react_pulse;
  modport source (output valid, drive_state, status, online, drive_on_pulse,
                  drive_off_pulse, power_cut_pulse, quick_stop_pulse,
                  fault_react_pulse, input ready);
  modport sink (input valid, drive_state, status, online, drive_on_pulse,
                drive_off_pulse, power_cut_pulse, quick_stop_pulse,
                fault_react_pulse, output ready);
endinterface

interface dpsm_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/dpsm_cw_decode.sv @@
// Control word decoder: maps a 16-bit control word to one command.
// Depends on dpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpsm_cw_decode
  import dpsm_pkg::*;
(
  input  wire logic [15:0] control_word,
  output command_t         command
);

  // Tests run in priority order; the first match wins.
  always_comb begin
    if ((control_word & CW_SHUTDOWN_MASK) == CW_SHUTDOWN_VAL) begin
      command = CMD_SHUTDOWN;
    end else if ((control_word & CW_SWITCH_ON_MASK) == CW_SWITCH_ON_VAL) begin
      command = CMD_SWITCH_ON;
    end else if ((control_word & CW_DIS_VOLT_MASK) == CW_DIS_VOLT_VAL) begin
      command = CMD_DISABLE_VOLTAGE;
    end else if ((control_word & CW_QUICK_STOP_MASK) == CW_QUICK_STOP_VAL) begin
      command = CMD_QUICK_STOP;
    end else if ((control_word & CW_ENABLE_OP_MASK) == CW_ENABLE_OP_VAL) begin
      command = CMD_ENABLE_OP;
    end else if ((control_word & CW_FAULT_RST_MASK) == CW_FAULT_RST_VAL) begin
      command = CMD_FAULT_RESET;
    end else begin
      command = CMD_NONE;
    end
  end

endmodule

`default_nettype wire

@@ sv/dpsm_transition.sv @@
// Next-state and action logic for one step of the drive state machine.
// Depends on dpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpsm_transition
  import dpsm_pkg::*;
(
  input  wire drive_state_t state,
  input  wire logic [1:0]   mode,
  input  wire command_t     command,
  input  wire logic         quick_stop_leave_enable,
  output step_result_t      result
);

  always_comb begin
    result            = '0;
    result.next_state = state;
    case (mode)
      MODE_STARTUP: begin
        // Start-up runs from start on to switch-on disabled; from any other state it is illegal.
        if (state == ST_START) begin
          result.next_state = ST_SW_DISABLED;
          result.set_online = 1'b1;
        end else begin
          result.illegal = 1'b1;
        end
      end
      MODE_FAULT: begin
        // Fault reaction completes within the same step.
        result.next_state         = ST_FAULT;
        result.pulses.drive_off   = 1'b1;
        result.pulses.fault_react = 1'b1;
      end
      MODE_CONTROL_WORD: begin
        case (command)
          CMD_SHUTDOWN: begin
            if (state == ST_SW_DISABLED) begin
              result.next_state = ST_READY;
            end else if (state inside {ST_SWITCHED_ON, ST_OP_ENABLED}) begin
              result.next_state       = ST_READY;
              result.pulses.power_cut = 1'b1;
            end else begin
              result.illegal = 1'b1;
            end
          end
          CMD_SWITCH_ON: begin
            // Outside ready and enabled this word is simply ignored.
            if (state == ST_READY) begin
              result.next_state = ST_SWITCHED_ON;
            end else if (state == ST_OP_ENABLED) begin
              result.next_state       = ST_SWITCHED_ON;
              result.pulses.drive_off = 1'b1;
            end
          end
          CMD_DISABLE_VOLTAGE: begin
            if (state == ST_READY) begin
              result.next_state = ST_SW_DISABLED;
            end else if (state inside {ST_OP_ENABLED, ST_SWITCHED_ON, ST_QUICK_STOP}) begin
              result.next_state       = ST_SW_DISABLED;
              result.pulses.power_cut = 1'b1;
            end else begin
              result.illegal = 1'b1;
            end
          end
          CMD_QUICK_STOP: begin
            if (state == ST_READY) begin
              result.next_state = ST_SW_DISABLED;
            end else if (state == ST_SWITCHED_ON) begin
              result.next_state       = ST_SW_DISABLED;
              result.pulses.power_cut = 1'b1;
            end else if (state == ST_OP_ENABLED) begin
              result.next_state        = ST_QUICK_STOP;
              result.pulses.quick_stop = 1'b1;
            end else begin
              result.illegal = 1'b1;
            end
          end
          CMD_ENABLE_OP: begin
            if ((state inside {ST_READY, ST_SWITCHED_ON}) ||
                (state == ST_QUICK_STOP && quick_stop_leave_enable)) begin
              result.next_state      = ST_OP_ENABLED;
              result.pulses.drive_on = 1'b1;
            end else begin
              result.illegal = 1'b1;
            end
          end
          CMD_FAULT_RESET: begin
            if (state == ST_FAULT) begin
              result.next_state = ST_SW_DISABLED;
            end else begin
              result.illegal = 1'b1;
            end
          end
          default: begin
            result.next_state = state;
          end
        endcase
      end
      default: begin
        result.next_state = state;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/drive_power_state_machine_core.sv @@
// Drive power state machine, top level.
// A beat is held in the command register, then moves on to the response register
// (which drives rsp.valid) once that is free or draining. Throughput: one beat per
// cycle unless rsp.ready stalls it. Reset: state returns to start, online flag and
// quick-stop option clear, both pipeline registers empty. Depends on dpsm_pkg,
// dpsm_cw_decode, dpsm_transition and the dpsm interfaces.
`timescale 1ns / 1ps
`default_nettype none

module drive_power_state_machine_core
  import dpsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dpsm_cmd_if.sink   cmd,
  dpsm_rsp_if.source rsp,
  dpsm_cfg_if.sink   cfg
);

  logic         cmd_valid_q;
  logic [1:0]   mode_q;
  logic [15:0]  control_word_q;
  drive_state_t state;
  logic         online_flag;
  logic         quick_stop_leave_enable;
  logic         rsp_valid;
  logic         advance;
  logic         online_next;
  command_t     command;
  step_result_t result;

  dpsm_cw_decode u_decode (
    .control_word (control_word_q),
    .command      (command)
  );

  dpsm_transition u_transition (
    .state                   (state),
    .mode                    (mode_q),
    .command                 (command),
    .quick_stop_leave_enable (quick_stop_leave_enable),
    .result                  (result)
  );

  // The held beat moves on when the result register is free or draining.
  assign advance     = cmd_valid_q && (!rsp_valid || rsp.ready);
  assign cmd.ready   = !cmd_valid_q || advance;
  assign cfg.ready   = 1'b1;
  assign online_next = online_flag | result.set_online;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid_q <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      mode_q         <= cmd.mode;
      control_word_q <= cmd.control_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quick_stop_leave_enable <= 1'b0;
    end else if (cfg.valid) begin
      quick_stop_leave_enable <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_START;
      online_flag <= 1'b0;
    end else if (advance) begin
      state       <= result.next_state;
      online_flag <= online_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (advance) begin
      rsp.drive_state       <= 4'(result.next_state);
      rsp.status            <= result.illegal;
      rsp.online            <= online_next;
      rsp.drive_on_pulse    <= result.pulses.drive_on;
      rsp.drive_off_pulse   <= result.pulses.drive_off;
      rsp.power_cut_pulse   <= result.pulses.power_cut;
      rsp.quick_stop_pulse  <= result.pulses.quick_stop;
      rsp.fault_react_pulse <= result.pulses.fault_react;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

@@ tb/sv/tb_drive_power_state_machine_core.sv @@
// Self-checking testbench for drive_power_state_machine_core: a directed table, then
// random command beats checked against an in-bench model of the drive state machine.
// Depends on dpsm_pkg, the dpsm interfaces and the core itself.
`timescale 1ns / 1ps

module tb_drive_power_state_machine_core;
  import dpsm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_BEATS = 362;

  typedef struct packed {
    drive_state_t drive_state;
    logic         status;
    logic         online;
    logic         drive_on;
    logic         drive_off;
    logic         power_cut;
    logic         quick_stop;
    logic         fault_react;
  } drive_outcome_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   mode;
    logic [15:0]  word;
    logic         pinned;
    drive_state_t pin_state;
    logic         pin_status;
  } plan_row_t;

  localparam int N_PLAN = 29;

  // Pinned rows carry a state and status that follow directly from the transition rules.
  plan_row_t dir_plan [N_PLAN] = '{
    '{ROW_CFG,  MODE_CONTROL_WORD, 16'h0000, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0006, 1'b1, ST_START,       1'b1},
    '{ROW_BEAT, MODE_UNUSED,       16'hFFFF, 1'b1, ST_START,       1'b0},
    '{ROW_BEAT, MODE_STARTUP,      16'h0000, 1'b1, ST_SW_DISABLED, 1'b0},
    '{ROW_BEAT, MODE_STARTUP,      16'h0000, 1'b1, ST_SW_DISABLED, 1'b1},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0000, 1'b1, ST_SW_DISABLED, 1'b1},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'hFF7E, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0007, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h000F, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0007, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'hFF7F, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0002, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h000F, 1'b1, ST_QUICK_STOP,  1'b1},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0007, 1'b1, ST_QUICK_STOP,  1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0080, 1'b1, ST_QUICK_STOP,  1'b1},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0000, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0006, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h000F, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0006, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_FAULT,        16'hFFFF, 1'b1, ST_FAULT,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0006, 1'b1, ST_FAULT,       1'b1},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'hFFFF, 1'b1, ST_SW_DISABLED, 1'b0},
    '{ROW_BEAT, MODE_FAULT,        16'h0000, 1'b1, ST_FAULT,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0080, 1'b0, ST_START,       1'b0},
    '{ROW_CFG,  MODE_CONTROL_WORD, 16'h0001, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0006, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h000F, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h0002, 1'b0, ST_START,       1'b0},
    '{ROW_BEAT, MODE_CONTROL_WORD, 16'h000F, 1'b1, ST_OP_ENABLED,  1'b0}
  };

  logic clk;
  logic rst;
  logic steady;

  dpsm_cmd_if cmd_ch ();
  dpsm_rsp_if rsp_ch ();
  dpsm_cfg_if cfg_ch ();

  drive_power_state_machine_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Model state of the drive and its one option bit.
  drive_state_t drive_st;
  logic         drive_online;
  logic         qs_leave_enable;

  drive_outcome_t outcome_q [$];
  drive_outcome_t want;
  drive_outcome_t got;
  int errors;
  int beats_sent;
  int results_seen;
  int rejects_seen;
  int qs_resumes;

  function automatic drive_outcome_t next_drive_outcome(input logic [1:0] m,
                                                        input logic [15:0] w);
    drive_outcome_t o;
    drive_state_t s;
    s = drive_st;
    o = '0;
    o.drive_state = s;
    if (m == MODE_STARTUP) begin
      if (s == ST_START) begin
        o.drive_state = ST_SW_DISABLED;
        drive_online = 1'b1;
      end else begin
        o.status = 1'b1;
      end
    end else if (m == MODE_FAULT) begin
      o.drive_state = ST_FAULT;
      o.drive_off = 1'b1;
      o.fault_react = 1'b1;
    end else if (m == MODE_CONTROL_WORD) begin
      if ((w & CW_SHUTDOWN_MASK) == CW_SHUTDOWN_VAL) begin
        case (s)
          ST_SW_DISABLED: o.drive_state = ST_READY;
          ST_SWITCHED_ON, ST_OP_ENABLED: begin
            o.power_cut = 1'b1;
            o.drive_state = ST_READY;
          end
          default: o.status = 1'b1;
        endcase
      end else if ((w & CW_SWITCH_ON_MASK) == CW_SWITCH_ON_VAL) begin
        // Outside ready and enabled this word is simply not an event.
        if (s == ST_READY) begin
          o.drive_state = ST_SWITCHED_ON;
        end else if (s == ST_OP_ENABLED) begin
          o.drive_state = ST_SWITCHED_ON;
          o.drive_off = 1'b1;
        end
      end else if ((w & CW_DIS_VOLT_MASK) == CW_DIS_VOLT_VAL) begin
        case (s)
          ST_READY: o.drive_state = ST_SW_DISABLED;
          ST_OP_ENABLED, ST_SWITCHED_ON, ST_QUICK_STOP: begin
            o.power_cut = 1'b1;
            o.drive_state = ST_SW_DISABLED;
          end
          default: o.status = 1'b1;
        endcase
      end else if ((w & CW_QUICK_STOP_MASK) == CW_QUICK_STOP_VAL) begin
        case (s)
          ST_READY: o.drive_state = ST_SW_DISABLED;
          ST_SWITCHED_ON: begin
            o.power_cut = 1'b1;
            o.drive_state = ST_SW_DISABLED;
          end
          ST_OP_ENABLED: begin
            o.quick_stop = 1'b1;
            o.drive_state = ST_QUICK_STOP;
          end
          default: o.status = 1'b1;
        endcase
      end else if ((w & CW_ENABLE_OP_MASK) == CW_ENABLE_OP_VAL) begin
        if (s == ST_READY || s == ST_SWITCHED_ON ||
            (s == ST_QUICK_STOP && qs_leave_enable)) begin
          if (s == ST_QUICK_STOP) qs_resumes++;
          o.drive_on = 1'b1;
          o.drive_state = ST_OP_ENABLED;
        end else begin
          o.status = 1'b1;
        end
      end else if ((w & CW_FAULT_RST_MASK) == CW_FAULT_RST_VAL) begin
        if (s == ST_FAULT) o.drive_state = ST_SW_DISABLED;
        else o.status = 1'b1;
      end
    end
    drive_st = o.drive_state;
    o.online = drive_online;
    if (o.status) rejects_seen++;
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("%0t: run did not finish in time", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  task automatic report_field(input string name, input logic [3:0] exp_v,
                              input logic [3:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = '{drive_state_t'(rsp_ch.drive_state), rsp_ch.status, rsp_ch.online,
              rsp_ch.drive_on_pulse, rsp_ch.drive_off_pulse, rsp_ch.power_cut_pulse,
              rsp_ch.quick_stop_pulse, rsp_ch.fault_react_pulse};
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: response beat with nothing expected, got %h", $time, got);
      end else begin
        want = outcome_q.pop_front();
        results_seen++;
        report_field("drive_state", want.drive_state, got.drive_state);
        report_field("status", want.status, got.status);
        report_field("online", want.online, got.online);
        report_field("drive_on_pulse", want.drive_on, got.drive_on);
        report_field("drive_off_pulse", want.drive_off, got.drive_off);
        report_field("power_cut_pulse", want.power_cut, got.power_cut);
        report_field("quick_stop_pulse", want.quick_stop, got.quick_stop);
        report_field("fault_react_pulse", want.fault_react, got.fault_react);
      end
    end
  end

  // Sends one command beat; a pinned beat replaces the expected state and status from the model.
  task automatic send_beat(input logic [1:0] m, input logic [15:0] w, input logic pinned,
                           input drive_state_t pin_state, input logic pin_status);
    drive_outcome_t o;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 20) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.control_word <= w;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    o = next_drive_outcome(m, w);
    if (pinned) begin
      o.drive_state = pin_state;
      o.status = pin_status;
    end
    outcome_q.push_back(o);
    beats_sent++;
  endtask

  task automatic settle_pipeline();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_option(input logic v);
    settle_pipeline();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    qs_leave_enable = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [1:0] m;
    logic [15:0] w;
    command_t c;
    int pick;
    int n;
    rst = 1'b1;
    steady = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_CONTROL_WORD;
    cmd_ch.control_word = 16'h0000;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    drive_st = ST_START;
    drive_online = 1'b0;
    qs_leave_enable = 1'b0;
    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    rejects_seen = 0;
    qs_resumes = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_CFG) begin
        write_option(dir_plan[i].word[0]);
      end else begin
        send_beat(dir_plan[i].mode, dir_plan[i].word, dir_plan[i].pinned,
                  dir_plan[i].pin_state, dir_plan[i].pin_status);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_option(phase[0]);
      steady = (phase == 2);
      n = 0;
      while (n < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) m = MODE_FAULT;
        else if (pick < 6) m = MODE_STARTUP;
        else if (pick < 8) m = MODE_UNUSED;
        else m = MODE_CONTROL_WORD;
        w = 16'($urandom_range(0, 16'hFFFF));
        // Most words carry one clean command with random don't-care bits.
        if (m == MODE_CONTROL_WORD && $urandom_range(0, 9) != 0) begin
          if (drive_st == ST_FAULT && $urandom_range(0, 1) == 1) c = CMD_FAULT_RESET;
          else c = command_t'($urandom_range(CMD_SHUTDOWN, CMD_FAULT_RESET));
          case (c)
            CMD_SHUTDOWN:        w = (w & ~CW_SHUTDOWN_MASK) | CW_SHUTDOWN_VAL;
            CMD_SWITCH_ON:       w = (w & ~CW_SWITCH_ON_MASK) | CW_SWITCH_ON_VAL;
            CMD_DISABLE_VOLTAGE: w = (w & ~CW_DIS_VOLT_MASK) | CW_DIS_VOLT_VAL;
            CMD_QUICK_STOP:      w = (w & ~CW_QUICK_STOP_MASK) | CW_QUICK_STOP_VAL;
            CMD_ENABLE_OP:       w = (w & ~CW_ENABLE_OP_MASK) | CW_ENABLE_OP_VAL;
            default:             w = (w & ~CW_FAULT_RST_MASK) | CW_FAULT_RST_VAL;
          endcase
        end
        send_beat(m, w, 1'b0, ST_START, 1'b0);
        if (m != MODE_UNUSED) n++;
        if ($urandom_range(0, 119) == 0) settle_pipeline();
      end
    end

    steady = 1'b0;
    settle_pipeline();
    repeat (8) @(posedge clk);
    $display("Covered %0d command beats and %0d checked responses over both option settings.",
             beats_sent, results_seen);
    $display("Rejected commands: %0d; quick-stop exits straight to enabled: %0d.",
             rejects_seen, qs_resumes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
